### hdl/sch_pkg.sv
// Shared types and constants for the swept circle closest-hit block.
`default_nettype none
package sch_pkg;
  localparam int CoordW = 20;
  localparam int RadW = 16;
  localparam int KindW = 3;
  localparam int IdxW = 6;
  localparam int DeltaW = CoordW + 1;
  localparam int DenW = 2 * DeltaW + 1;
  localparam int SqW = 2 * DeltaW + 1;
  localparam int NumW = 2 * (CoordW + 2) + 1;
  localparam int EntryW = 2 * CoordW + RadW + KindW + 1;
  localparam int DivSteps = DeltaW;
  localparam int DivCntW = $clog2(DivSteps + 1);

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_ISSUE,
    ST_LOAD,
    ST_CLASS,
    ST_DIV,
    ST_EVAL
  } sch_state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [RadW-1:0] radius;
    logic [KindW-1:0] kind;
    logic valid;
  } sch_entry_t;
endpackage
`default_nettype wire

### hdl/sch_if.sv
// Valid-ready channel interfaces for requests and results.
`default_nettype none
interface sch_req_if;
  logic valid;
  logic ready;
  logic func;
  logic [5:0] index;
  logic valid_req;
  logic [2:0] kind;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [19:0] end_x;
  logic signed [19:0] end_y;
  logic [15:0] radius;
  modport source(output valid, func, index, valid_req, kind, pos_x, pos_y, end_x, end_y, radius,
                 input ready);
  modport sink(input valid, func, index, valid_req, kind, pos_x, pos_y, end_x, end_y, radius,
               output ready);
endinterface

interface sch_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic [5:0] hit_index;
  logic signed [19:0] hit_x;
  logic signed [19:0] hit_y;
  modport source(output valid, hit, hit_index, hit_x, hit_y, input ready);
  modport sink(input valid, hit, hit_index, hit_x, hit_y, output ready);
endinterface
`default_nettype wire

### hdl/sch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sch_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input wire logic clk,
  input wire logic wr_en,
  input wire logic [$clog2(Depth)-1:0] wr_addr,
  input wire logic [Width-1:0] wr_data,
  input wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### hdl/sch_div.sv
// Serial multiply-divide unit giving round(mag * num / den), one magnitude bit per cycle.
`default_nettype none
module sch_div (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [sch_pkg::DeltaW-1:0] mag,
  input wire logic [sch_pkg::DenW-1:0] num,
  input wire logic [sch_pkg::DenW-1:0] den,
  output logic busy,
  output logic [sch_pkg::DeltaW-1:0] quotient
);
  import sch_pkg::*;

  logic [DeltaW-1:0] bits;
  logic [DeltaW-1:0] quo;
  logic [DenW-1:0] rem;
  logic [DenW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic [DivCntW-1:0] count;
  logic [DenW+1:0] acc;
  logic [DenW+1:0] acc_1;
  logic [DenW+1:0] acc_2;
  logic round_up;

  // The remainder stays below den, so one step adds at most two to the quotient.
  assign acc = {1'b0, rem, 1'b0} + (bits[DeltaW-1] ? {2'b00, num_r} : '0);
  assign acc_1 = acc - {2'b00, den_r};
  assign acc_2 = acc - {1'b0, den_r, 1'b0};
  assign round_up = {rem, 1'b0} >= {1'b0, den_r};
  assign quotient = quo + {{(DeltaW-1){1'b0}}, round_up};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      bits <= '0;
      quo <= '0;
      rem <= '0;
      num_r <= '0;
      den_r <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= DivCntW'(DivSteps);
      bits <= mag;
      quo <= '0;
      rem <= '0;
      num_r <= num;
      den_r <= den;
    end else if (busy) begin
      bits <= {bits[DeltaW-2:0], 1'b0};
      if (!acc_2[DenW+1]) begin
        rem <= acc_2[DenW-1:0];
        quo <= {quo[DeltaW-2:0], 1'b0} + DeltaW'(2);
      end else if (!acc_1[DenW+1]) begin
        rem <= acc_1[DenW-1:0];
        quo <= {quo[DeltaW-2:0], 1'b1};
      end else begin
        rem <= acc[DenW-1:0];
        quo <= {quo[DeltaW-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == DivCntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/swept_circle_closest_hit.sv
// Top level: entity table in RAM and the closest-hit query sequencer.
//
//  channel | role   | transaction
//  req     | sink   | write one entry, or run one query
//  rsp     | source | one result per request
//
// After reset a clearing pass writes every entry, one per cycle, with the request side
// held off. A write is answered in the cycle after it is accepted.
// A query spends a setup step computing the segment's squared length, then for each
// entry reads it, classifies it and either skips it, evaluates a segment end as the
// closest point, or first runs two parallel serial dividers to place it inside the
// segment. The request side stalls while a result waits to be taken.
`default_nettype none
module swept_circle_closest_hit #(
  parameter int TABLE_DEPTH = 64,
  parameter int KIND_COUNT = 8
) (
  input wire logic clk,
  input wire logic rst,
  sch_req_if.sink req,
  sch_rsp_if.source rsp
);
  import sch_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = ((AW > IdxW) ? AW : IdxW) + 1;
  localparam int KCW = KindW + 2;

  sch_state_t state, state_next;
  logic [AW-1:0] ptr;
  logic last_entry;
  logic req_fire;
  logic rsp_fire;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [EntryW-1:0] wr_data;
  sch_entry_t wr_entry;
  sch_entry_t rd_entry;
  logic [EntryW-1:0] rd_raw;

  logic q_excl;
  logic [IdxW-1:0] q_idx;
  logic [KindW-1:0] q_kind;
  logic skip_q;
  logic signed [CoordW-1:0] sx, sy, ex, ey;
  logic [RadW-1:0] q_rad;
  logic signed [DeltaW-1:0] dx, dy;
  logic [DeltaW-1:0] mag_x, mag_y;
  logic [DenW-1:0] den;

  logic signed [DeltaW-1:0] cx, cy;
  logic signed [NumW-1:0] num_calc;
  logic signed [NumW-1:0] num;
  logic ent_match;
  logic ent_ok;
  logic signed [CoordW-1:0] cur_x, cur_y;
  logic [RadW-1:0] cur_rad;
  logic num_low, num_high;
  logic div_start;
  logic div_busy_x, div_busy_y;
  logic [DeltaW-1:0] quo_x, quo_y;
  logic signed [DeltaW-1:0] ix, iy;
  logic signed [CoordW-1:0] px, py;
  logic signed [DeltaW-1:0] qx, qy, wx, wy;
  logic [SqW-1:0] dist2, toward2, reach2;
  logic [RadW:0] rsum;
  logic hit_now;

  logic found;
  logic [IdxW-1:0] best_idx;
  logic [SqW-1:0] best_d2;
  logic signed [CoordW-1:0] best_x, best_y;
  logic out_valid;

  sch_ram #(.Width(EntryW), .Depth(TABLE_DEPTH)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(ptr), .rd_data(rd_raw)
  );

  sch_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .mag(mag_x), .num(num[DenW-1:0]),
    .den(den), .busy(div_busy_x), .quotient(quo_x)
  );

  sch_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .mag(mag_y), .num(num[DenW-1:0]),
    .den(den), .busy(div_busy_y), .quotient(quo_y)
  );

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;
  assign req.ready = (state == ST_IDLE) && !out_valid;
  assign last_entry = (ptr == AW'(TABLE_DEPTH - 1));

  assign wr_entry = '{x: req.pos_x, y: req.pos_y, radius: req.radius, kind: req.kind,
                      valid: req.valid_req};
  assign wr_en = (state == ST_CLEAR)
                 || (req_fire && (req.func == FuncWrite)
                     && (CW'(req.index) < CW'(TABLE_DEPTH)));
  assign wr_addr = (state == ST_CLEAR) ? ptr : AW'(req.index);
  assign wr_data = (state == ST_CLEAR) ? '0 : wr_entry;
  assign rd_entry = sch_entry_t'(rd_raw);

  assign rsp.valid = out_valid;
  assign rsp.hit = found;
  assign rsp.hit_index = found ? best_idx : '0;
  assign rsp.hit_x = found ? best_x : '0;
  assign rsp.hit_y = found ? best_y : '0;

  assign cx = DeltaW'(rd_entry.x) - DeltaW'(sx);
  assign cy = DeltaW'(rd_entry.y) - DeltaW'(sy);
  assign num_calc = NumW'(cx * dx) + NumW'(cy * dy);
  assign ent_match = rd_entry.valid && (rd_entry.kind == q_kind)
                     && !(q_excl && (CW'(q_idx) == CW'(ptr)))
                     && !skip_q && (den != '0);

  assign num_low = num[NumW-1] || (num == '0);
  assign num_high = !num_low && (num >= $signed(NumW'(den)));
  assign div_start = (state == ST_CLASS) && ent_ok && !num_low && !num_high;

  assign mag_x = dx[DeltaW-1] ? -dx : dx;
  assign mag_y = dy[DeltaW-1] ? -dy : dy;
  assign ix = dx[DeltaW-1] ? DeltaW'(sx) - $signed(quo_x) : DeltaW'(sx) + $signed(quo_x);
  assign iy = dy[DeltaW-1] ? DeltaW'(sy) - $signed(quo_y) : DeltaW'(sy) + $signed(quo_y);

  assign qx = DeltaW'(cur_x) - DeltaW'(px);
  assign qy = DeltaW'(cur_y) - DeltaW'(py);
  assign wx = DeltaW'(px) - DeltaW'(sx);
  assign wy = DeltaW'(py) - DeltaW'(sy);
  assign dist2 = SqW'(qx * qx) + SqW'(qy * qy);
  assign toward2 = SqW'(wx * wx) + SqW'(wy * wy);
  assign rsum = {1'b0, cur_rad} + {1'b0, q_rad};
  assign reach2 = SqW'(rsum * rsum);
  assign hit_now = dist2 < reach2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (last_entry) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire && (req.func == FuncQuery)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_CLASS;
      ST_CLASS: begin
        if (!ent_ok) begin
          state_next = last_entry ? ST_IDLE : ST_ISSUE;
        end else if (div_start) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_DIV: begin
        if (!div_busy_x) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: state_next = last_entry ? ST_IDLE : ST_ISSUE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      out_valid <= 1'b0;
      found <= 1'b0;
      best_idx <= '0;
      best_d2 <= '0;
      best_x <= '0;
      best_y <= '0;
      q_excl <= 1'b0;
      q_idx <= '0;
      q_kind <= '0;
      skip_q <= 1'b0;
      sx <= '0;
      sy <= '0;
      ex <= '0;
      ey <= '0;
      q_rad <= '0;
      dx <= '0;
      dy <= '0;
      den <= '0;
      cur_x <= '0;
      cur_y <= '0;
      cur_rad <= '0;
      num <= '0;
      ent_ok <= 1'b0;
      px <= '0;
      py <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          ptr <= last_entry ? '0 : ptr + 1'b1;
        end
        ST_IDLE: begin
          if (req_fire) begin
            ptr <= '0;
            found <= 1'b0;
            q_excl <= req.valid_req;
            q_idx <= req.index;
            q_kind <= req.kind;
            skip_q <= KCW'(req.kind) >= KCW'(KIND_COUNT);
            sx <= req.pos_x;
            sy <= req.pos_y;
            ex <= req.end_x;
            ey <= req.end_y;
            q_rad <= req.radius;
            dx <= DeltaW'(req.end_x) - DeltaW'(req.pos_x);
            dy <= DeltaW'(req.end_y) - DeltaW'(req.pos_y);
            if (req.func == FuncWrite) begin
              out_valid <= 1'b1;
            end
          end else if (rsp_fire) begin
            out_valid <= 1'b0;
          end
        end
        ST_PREP: begin
          den <= DenW'(dx * dx) + DenW'(dy * dy);
        end
        ST_LOAD: begin
          cur_x <= rd_entry.x;
          cur_y <= rd_entry.y;
          cur_rad <= rd_entry.radius;
          num <= num_calc;
          ent_ok <= ent_match;
        end
        ST_CLASS: begin
          if (num_low) begin
            px <= sx;
            py <= sy;
          end else if (num_high) begin
            px <= ex;
            py <= ey;
          end
          if (!ent_ok) begin
            if (last_entry) begin
              out_valid <= 1'b1;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (!div_busy_x) begin
            px <= ix[CoordW-1:0];
            py <= iy[CoordW-1:0];
          end
        end
        ST_EVAL: begin
          if (hit_now && (!found || (toward2 < best_d2))) begin
            found <= 1'b1;
            best_d2 <= toward2;
            best_idx <= IdxW'(ptr);
            best_x <= px;
            best_y <= py;
          end
          if (last_entry) begin
            out_valid <= 1'b1;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  property p_ready_blocks;
    @(posedge clk) disable iff (rst) out_valid |-> !req.ready;
  endproperty
  a_ready_blocks: assert property (p_ready_blocks) else $error("ready while result pending");

  property p_rsp_hold;
    @(posedge clk) disable iff (rst)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.hit) && $stable(rsp.hit_index)
                                     && $stable(rsp.hit_x) && $stable(rsp.hit_y));
  endproperty
  a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while waiting");

  property p_ptr_range;
    @(posedge clk) disable iff (rst) CW'(ptr) < CW'(TABLE_DEPTH);
  endproperty
  a_ptr_range: assert property (p_ptr_range) else $error("scan pointer overran");

  property p_div_lockstep;
    @(posedge clk) disable iff (rst) (state == ST_DIV) |-> (div_busy_x == div_busy_y);
  endproperty
  a_div_lockstep: assert property (p_div_lockstep) else $error("dividers out of step");
endmodule
`default_nettype wire

### tb/sv/tb_swept_circle_closest_hit.sv
// Testbench for swept_circle_closest_hit with a scoreboard predictor.
module tb_swept_circle_closest_hit;
  timeunit 1ns;
  timeprecision 1ps;
  import sch_pkg::*;

  localparam int Depth = 64;
  localparam int Kinds = 8;
  localparam int StallLimit = 40000;

  typedef struct {
    logic func;
    logic [5:0] index;
    logic valid_req;
    logic [2:0] kind;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] end_x;
    logic signed [19:0] end_y;
    logic [15:0] radius;
  } request_t;

  typedef struct {
    logic hit;
    logic [5:0] hit_index;
    logic signed [19:0] hit_x;
    logic signed [19:0] hit_y;
  } hit_result_t;

  class hit_scoreboard;
    longint ent_x[Depth];
    longint ent_y[Depth];
    longint ent_r[Depth];
    int ent_kind[Depth];
    bit ent_valid[Depth];
    hit_result_t expected_hits[$];
    int mismatches;

    function new();
      mismatches = 0;
      foreach (ent_valid[i]) ent_valid[i] = 0;
    endfunction

    function longint lerp(longint s, longint d, longint num, longint den);
      longint mag;
      longint q;
      mag = (d < 0) ? -d : d;
      q = (2 * mag * num + den) / (2 * den);
      return (d < 0) ? s - q : s + q;
    endfunction

    function void note_request(request_t r);
      hit_result_t e;
      longint sx, sy, ex, ey, dx, dy, den, cx, cy, num, px, py, qx, qy, d2, rs, wx, wy, t2;
      longint best;
      e = '{hit: 0, hit_index: 0, hit_x: 0, hit_y: 0};
      best = 0;
      sx = r.pos_x;
      sy = r.pos_y;
      ex = r.end_x;
      ey = r.end_y;
      if (r.func == FuncWrite) begin
        ent_x[r.index] = sx;
        ent_y[r.index] = sy;
        ent_r[r.index] = r.radius;
        ent_kind[r.index] = r.kind;
        ent_valid[r.index] = r.valid_req;
      end else begin
        dx = ex - sx;
        dy = ey - sy;
        den = dx * dx + dy * dy;
        if (den != 0 && r.kind < Kinds) begin
          for (int i = 0; i < Depth; i++) begin
            if (!ent_valid[i] || ent_kind[i] != r.kind) continue;
            if (r.valid_req && i == r.index) continue;
            cx = ent_x[i] - sx;
            cy = ent_y[i] - sy;
            num = cx * dx + cy * dy;
            if (num <= 0) begin
              px = sx;
              py = sy;
            end else if (num >= den) begin
              px = ex;
              py = ey;
            end else begin
              px = lerp(sx, dx, num, den);
              py = lerp(sy, dy, num, den);
            end
            qx = ent_x[i] - px;
            qy = ent_y[i] - py;
            d2 = qx * qx + qy * qy;
            rs = ent_r[i] + r.radius;
            if (d2 >= rs * rs) continue;
            wx = px - sx;
            wy = py - sy;
            t2 = wx * wx + wy * wy;
            if (!e.hit || t2 < best) begin
              e.hit = 1;
              best = t2;
              e.hit_index = i[5:0];
              e.hit_x = px[19:0];
              e.hit_y = py[19:0];
            end
          end
        end
      end
      expected_hits.push_back(e);
    endfunction

    function void check_result(hit_result_t a);
      hit_result_t e;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: hit=%0d idx=%0d x=%0d y=%0d",
                                       a.hit, a.hit_index, a.hit_x, a.hit_y);
        return;
      end
      e = expected_hits.pop_front();
      if (a.hit !== e.hit || a.hit_index !== e.hit_index || a.hit_x !== e.hit_x ||
          a.hit_y !== e.hit_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected hit=%0d idx=%0d x=%0d y=%0d, %s%0d idx=%0d x=%0d y=%0d",
                   e.hit, e.hit_index, e.hit_x, e.hit_y, "got hit=",
                   a.hit, a.hit_index, a.hit_x, a.hit_y);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  sch_req_if req_ch();
  sch_rsp_if rsp_ch();
  hit_scoreboard sb;
  int accepted_reqs = 0;
  bit quiet = 0;
  int idle_cycles = 0;

  swept_circle_closest_hit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      sb.note_request('{func: req_ch.func, index: req_ch.index, valid_req: req_ch.valid_req,
                        kind: req_ch.kind, pos_x: req_ch.pos_x, pos_y: req_ch.pos_y,
                        end_x: req_ch.end_x, end_y: req_ch.end_y, radius: req_ch.radius});
      accepted_reqs++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{hit: rsp_ch.hit, hit_index: rsp_ch.hit_index, hit_x: rsp_ch.hit_x,
                        hit_y: rsp_ch.hit_y});
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("swept_circle_closest_hit verification failed");
      $finish;
    end
  end

  initial begin
    bit held;
    held = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!held && accepted_reqs >= 120) begin
        held = 1;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_request(request_t r);
    req_ch.valid <= 1'b1;
    req_ch.func <= r.func;
    req_ch.index <= r.index;
    req_ch.valid_req <= r.valid_req;
    req_ch.kind <= r.kind;
    req_ch.pos_x <= r.pos_x;
    req_ch.pos_y <= r.pos_y;
    req_ch.end_x <= r.end_x;
    req_ch.end_y <= r.end_y;
    req_ch.radius <= r.radius;
    do @(posedge clk); while (!req_ch.ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic request_t entry_write(int idx, bit vld, int kind, int x, int y, int r);
    return '{func: FuncWrite, index: idx[5:0], valid_req: vld, kind: kind[2:0],
             pos_x: x[19:0], pos_y: y[19:0], end_x: 20'($urandom), end_y: 20'($urandom),
             radius: r[15:0]};
  endfunction

  function automatic request_t sweep_query(int kind, bit excl, int idx, int sx, int sy,
                                           int ex, int ey, int r);
    return '{func: FuncQuery, index: idx[5:0], valid_req: excl, kind: kind[2:0],
             pos_x: sx[19:0], pos_y: sy[19:0], end_x: ex[19:0], end_y: ey[19:0],
             radius: r[15:0]};
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 8000)) - 4000;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r = '{func: 1'($urandom), index: 6'($urandom), valid_req: 1'($urandom),
            kind: 3'($urandom), pos_x: 20'($urandom), pos_y: 20'($urandom),
            end_x: 20'($urandom), end_y: 20'($urandom), radius: 16'($urandom)};
    end else if (pick < 40) begin
      r = entry_write($urandom_range(0, 63), $urandom_range(0, 5) != 0, $urandom_range(0, 3),
                      near_coord(), near_coord(), $urandom_range(0, 900));
    end else begin
      r = sweep_query($urandom_range(0, 3), $urandom_range(0, 3) == 0, $urandom_range(0, 63),
                      near_coord(), near_coord(), near_coord(), near_coord(),
                      $urandom_range(0, 600));
      if ($urandom_range(0, 15) == 0) begin
        r.end_x = r.pos_x;
        r.end_y = r.pos_y;
      end
    end
    return r;
  endfunction

  initial begin
    request_t dir[$];
    sb = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= FuncWrite;
    req_ch.index <= '0;
    req_ch.valid_req <= 1'b0;
    req_ch.kind <= '0;
    req_ch.pos_x <= '0;
    req_ch.pos_y <= '0;
    req_ch.end_x <= '0;
    req_ch.end_y <= '0;
    req_ch.radius <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir.push_back(sweep_query(0, 0, 0, 0, 0, 1000, 0, 100));
    dir.push_back(entry_write(0, 1, 7, -524288, -524288, 65535));
    dir.push_back(entry_write(63, 1, 7, 524287, 524287, 65535));
    dir.push_back(sweep_query(7, 0, 0, -524288, -524288, 524287, 524287, 65535));
    dir.push_back(sweep_query(7, 1, 0, -524288, -524288, 524287, 524287, 0));
    dir.push_back(entry_write(1, 1, 2, 500, 50, 100));
    dir.push_back(entry_write(2, 1, 2, 500, 50, 100));
    dir.push_back(sweep_query(2, 0, 0, 0, 0, 1000, 0, 10));
    dir.push_back(sweep_query(2, 1, 1, 0, 0, 1000, 0, 10));
    dir.push_back(sweep_query(2, 0, 0, 500, 50, 500, 50, 1000));
    dir.push_back(sweep_query(2, 0, 0, 600, 0, 2000, 3, 300));
    dir.push_back(sweep_query(2, 0, 0, -900, 40, 450, 47, 300));
    dir.push_back(sweep_query(2, 0, 0, 0, 0, 1000, 0, 0));
    dir.push_back(entry_write(3, 1, 2, -333, -777, 40));
    dir.push_back(sweep_query(2, 0, 0, 0, 0, -700, -1550, 5));
    dir.push_back(entry_write(2, 0, 2, 500, 50, 100));
    dir.push_back(sweep_query(2, 1, 1, 0, 0, 1000, 0, 10));
    dir.push_back(sweep_query(5, 0, 0, 0, 0, 1000, 0, 5000));
    foreach (dir[i]) send_request(dir[i]);

    for (int n = 0; n < 400; n++) begin
      if (n >= 340) quiet = 1;
      send_request(random_request());
    end
    req_ch.valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_hits.size() == 0)
      $display("swept_circle_closest_hit verification clean");
    else
      $display("swept_circle_closest_hit verification failed");
    $finish;
  end
endmodule
